// ===== rtl/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, constants and helpers for the balanced-ternary ALU pipeline.
// ----------------------------------------------------------------------------
package bta_pkg;

  // trits kept in a result
  localparam int TRITS = 20;

  // field widths
  localparam int OPW = 4;
  localparam int VW  = 32;
  localparam int AW  = 5;
  localparam int DGW = 2;
  localparam int TRW = 40;
  localparam int XW  = VW + 2;

  // exact expansion length, even, covers any 34-bit signed value
  localparam int EXPT = 22;
  localparam int NCV  = EXPT / 2;

  // working length: expansion shifted left by the largest amount
  localparam int WT = EXPT + (1 << AW) - 1;

  // adder tree over the kept trits
  localparam int LVL   = $clog2(TRITS);
  localparam int NODES = (1 << LVL) - 1;

  // trits shown in result_trits
  localparam int PACKT = (TRITS < TRW / 2) ? TRITS : TRW / 2;

  // stream widths
  localparam int IN_BITS  = 2 * VW + AW + DGW;
  localparam int INW      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = VW + TRW + DGW;
  localparam int OUTW     = ((OUT_BITS + 7) / 8) * 8;

  function automatic logic [63:0] pow3(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd3;
    end
    return p;
  endfunction

  localparam logic [63:0] EXP_SPAN = pow3(EXPT);
  localparam int UW = $clog2(EXP_SPAN);
  // offset that maps a signed value onto plain ternary digits
  localparam logic [UW-1:0] OFFSET = UW'((EXP_SPAN - 64'd1) >> 1);

  // trit codes
  localparam logic [1:0] T_ZERO  = 2'b00;
  localparam logic [1:0] T_PLUS  = 2'b01;
  localparam logic [1:0] T_MINUS = 2'b11;
  localparam logic [1:0] T_BAD   = 2'b10;

  typedef enum logic [OPW-1:0] {
    OP_CONV = 4'd0,
    OP_AND  = 4'd1,
    OP_OR   = 4'd2,
    OP_SHR  = 4'd3,
    OP_SHL  = 4'd4,
    OP_ADD  = 4'd5,
    OP_SUB  = 4'd6,
    OP_GET  = 4'd7,
    OP_SET  = 4'd8
  } op_t;

  typedef logic [EXPT-1:0][1:0] xtr_t;
  typedef logic [WT-1:0][1:0]   wtr_t;

  typedef struct packed {
    op_t           op;
    logic [AW-1:0] amt;
    logic [1:0]    dg;
  } ctl_t;

  typedef struct packed {
    logic [TRW-1:0] trits;
    logic [1:0]     tout;
    logic           ovf;
  } side_t;

endpackage

// ===== rtl/bta_conv.sv =====
// ----------------------------------------------------------------------------
// bta_conv
// Pipelined conversion of an offset binary value into balanced-ternary trits,
// two trits per stage, most significant first.
// ----------------------------------------------------------------------------
module bta_conv import bta_pkg::*; (
  input  logic            clk,
  input  logic [NCV-1:0]  en,
  input  logic [UW-1:0]   u,
  output xtr_t            trits
);

  // returns {trit, remainder}
  function automatic logic [UW+1:0] digit_step(input logic [UW-1:0] r,
                                               input logic [UW-1:0] p);
    logic [UW:0]   d2;
    logic [UW:0]   d1;
    logic [UW+1:0] res;
    d2 = {1'b0, r} - {p, 1'b0};
    d1 = {1'b0, r} - {1'b0, p};
    priority if (!d2[UW]) begin
      res = {T_PLUS, d2[UW-1:0]};
    end else if (!d1[UW]) begin
      res = {T_ZERO, d1[UW-1:0]};
    end else begin
      res = {T_MINUS, r};
    end
    return res;
  endfunction

  logic [UW-1:0] rem [NCV-1];
  xtr_t          tv  [NCV];

  for (genvar k = 0; k < NCV; k++) begin : g_stage
    localparam int HI = EXPT - 1 - 2 * k;
    localparam logic [UW-1:0] P_HI = UW'(pow3(HI));
    localparam logic [UW-1:0] P_LO = UW'(pow3(HI - 1));

    logic [UW-1:0] rin;
    xtr_t          tin;
    xtr_t          tv_next;
    logic [UW+1:0] s_hi;
    logic [UW+1:0] s_lo;

    if (k == 0) begin : g_first
      assign rin = u;
      assign tin = '0;
    end else begin : g_next
      assign rin = rem[k-1];
      assign tin = tv[k-1];
    end

    assign s_hi = digit_step(rin, P_HI);
    assign s_lo = digit_step(s_hi[UW-1:0], P_LO);

    always_comb begin
      tv_next         = tin;
      tv_next[HI]     = s_hi[UW+1:UW];
      tv_next[HI - 1] = s_lo[UW+1:UW];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        tv[k] <= tv_next;
      end
    end

    if (k < NCV - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= s_lo[UW-1:0];
        end
      end
    end
  end

  assign trits = tv[NCV-1];

endmodule

// ===== rtl/bta_tritop.sv =====
// ----------------------------------------------------------------------------
// bta_tritop
// Trit-level operation stage: pass-through, min, max, shifts, trit read and
// trit write on the exact expansions, registered.
// ----------------------------------------------------------------------------
module bta_tritop import bta_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  xtr_t       ta,
  input  xtr_t       tb,
  input  ctl_t       ctl,
  output wtr_t       tr,
  output logic [1:0] tout
);

  function automatic logic [1:0] tmin(input logic [1:0] x, input logic [1:0] y);
    return ($signed(x) < $signed(y)) ? x : y;
  endfunction

  function automatic logic [1:0] tmax(input logic [1:0] x, input logic [1:0] y);
    return ($signed(x) > $signed(y)) ? x : y;
  endfunction

  logic [2*WT-1:0] xa;
  logic [2*WT-1:0] xb;
  wtr_t            tr_next;
  logic [1:0]      tout_next;

  assign xa = (2*WT)'(ta);
  assign xb = (2*WT)'(tb);

  always_comb begin
    tr_next   = '0;
    tout_next = T_ZERO;
    unique case (ctl.op)
      OP_CONV, OP_ADD, OP_SUB: begin
        tr_next = xa;
      end
      OP_GET: begin
        tr_next = xa;
        for (int i = 0; i < EXPT; i++) begin
          if (i == int'(ctl.amt)) begin
            tout_next = ta[i];
          end
        end
      end
      OP_AND: begin
        for (int i = 0; i < WT; i++) begin
          tr_next[i] = tmin(xa[2*i +: 2], xb[2*i +: 2]);
        end
      end
      OP_OR: begin
        for (int i = 0; i < WT; i++) begin
          tr_next[i] = tmax(xa[2*i +: 2], xb[2*i +: 2]);
        end
      end
      OP_SHR: begin
        tr_next = xa >> {ctl.amt, 1'b0};
      end
      OP_SHL: begin
        tr_next = xa << {ctl.amt, 1'b0};
      end
      OP_SET: begin
        tr_next = xa;
        for (int i = 0; i < WT; i++) begin
          if (i == int'(ctl.amt)) begin
            tr_next[i] = ctl.dg;
          end
        end
      end
      default: begin
        tr_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tr   <= tr_next;
      tout <= tout_next;
    end
  end

endmodule

// ===== rtl/bta_sum.sv =====
// ----------------------------------------------------------------------------
// bta_sum
// Registered adder tree that folds the kept trits back into a binary value,
// with packing and overflow detection carried alongside.
// ----------------------------------------------------------------------------
module bta_sum import bta_pkg::*; (
  input  logic           clk,
  input  logic [LVL-1:0] en,
  input  wtr_t           tr,
  input  logic [1:0]     tout,
  output logic [VW-1:0]  value,
  output side_t          side
);

  function automatic logic [VW-1:0] term(input logic [1:0] t, input logic [VW-1:0] p);
    logic [VW-1:0] res;
    unique case (t)
      T_PLUS:  res = p;
      T_MINUS: res = -p;
      default: res = '0;
    endcase
    return res;
  endfunction

  logic [VW-1:0]  node [NODES];
  side_t          side_q [LVL];
  logic [TRW-1:0] pack;
  logic           ovf;

  // packed view and overflow from the trits beyond the kept ones
  always_comb begin
    pack = '0;
    ovf  = 1'b0;
    for (int i = 0; i < PACKT; i++) begin
      pack[2*i +: 2] = tr[i];
    end
    for (int i = TRITS; i < WT; i++) begin
      ovf = ovf | (|tr[i]);
    end
  end

  for (genvar l = 1; l <= LVL; l++) begin : g_lvl
    localparam int OFF  = (1 << LVL) - (1 << (LVL - l + 1));
    localparam int POFF = (1 << LVL) - (1 << (LVL - l + 2));

    for (genvar j = 0; j < (1 << (LVL - l)); j++) begin : g_node
      if (l == 1) begin : g_leaf
        localparam int I0 = 2 * j;
        localparam int I1 = 2 * j + 1;
        logic [VW-1:0] t0;
        logic [VW-1:0] t1;

        if (I0 < TRITS) begin : g_t0
          assign t0 = term(tr[I0], VW'(pow3(I0)));
        end else begin : g_z0
          assign t0 = '0;
        end
        if (I1 < TRITS) begin : g_t1
          assign t1 = term(tr[I1], VW'(pow3(I1)));
        end else begin : g_z1
          assign t1 = '0;
        end

        always_ff @(posedge clk) begin
          if (en[0]) begin
            node[OFF + j] <= t0 + t1;
          end
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          if (en[l-1]) begin
            node[OFF + j] <= node[POFF + 2*j] + node[POFF + 2*j + 1];
          end
        end
      end
    end

    if (l == 1) begin : g_side_first
      always_ff @(posedge clk) begin
        if (en[0]) begin
          side_q[0] <= '{trits: pack, tout: tout, ovf: ovf};
        end
      end
    end else begin : g_side_next
      always_ff @(posedge clk) begin
        if (en[l-1]) begin
          side_q[l-1] <= side_q[l-2];
        end
      end
    end
  end

  assign value = node[NODES-1];
  assign side  = side_q[LVL-1];

endmodule

// ===== rtl/balanced_ternary_alu.sv =====
// ----------------------------------------------------------------------------
// balanced_ternary_alu
// Balanced-ternary arithmetic and trit-wise logic on signed binary operands,
// fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tdata: operand_a, operand_b, amount,
//                                     digit; tuser: operation
//  m_*      out  m_tvalid / m_tready  tdata: result_value, result_trits,
//                                     trit_out; tuser: overflow
//
//  one item per cycle sustained while m_tready holds; 2 input stages (operand
//  add/subtract, offset add), 11 conversion stages of two trits each, one
//  trit-operation stage and a 5-level adder tree ending in the output register
//  reset clears only the stage valid bits
//  each stage holds while the one after it is full and not moving; empty
//  stages fill up, so items are still taken while a result waits
// ----------------------------------------------------------------------------
module balanced_ternary_alu import bta_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [INW-1:0]  s_tdata,   // operand_a, operand_b, amount, digit
  input  logic [OPW-1:0]  s_tuser,   // operation
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OUTW-1:0] m_tdata,   // result_value, result_trits, trit_out
  output logic            m_tuser    // overflow
);

  localparam int NS    = 3 + NCV + LVL;
  localparam int S_CV  = 2;
  localparam int S_OP  = 2 + NCV;
  localparam int S_SUM = 3 + NCV;

  logic [NS-1:0] vld;
  logic [NS-1:0] vin;
  logic [NS-1:0] rdy;
  logic [NS-1:0] ld;

  // a stage may move when the output is ready or any stage from it to the output is empty
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      rdy[i] = m_tready || ((vld | ({NS{1'b1}} >> (NS - i))) != {NS{1'b1}});
    end
  end

  assign vin = {vld[NS-2:0], s_tvalid};
  assign ld  = vin & rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vin[i];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NS-1];

  // input fields
  logic signed [VW-1:0] in_a;
  logic signed [VW-1:0] in_b;
  logic [AW-1:0]        in_amt;
  logic [1:0]           in_dg;
  op_t                  in_op;

  assign in_a   = s_tdata[VW-1:0];
  assign in_b   = s_tdata[2*VW-1:VW];
  assign in_amt = s_tdata[2*VW +: AW];
  assign in_dg  = s_tdata[2*VW+AW +: DGW];
  assign in_op  = op_t'(s_tuser);

  // stage 1: value to expand
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] s1_x;
  logic signed [VW-1:0] s1_b;
  ctl_t                 s1_ctl;

  always_comb begin
    unique case (in_op)
      OP_ADD:  x_next = XW'(in_a) + XW'(in_b);
      OP_SUB:  x_next = XW'(in_a) - XW'(in_b);
      default: x_next = XW'(in_a);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_x   <= x_next;
      s1_b   <= in_b;
      // digit pattern 10 saturates to minus
      s1_ctl <= '{op: in_op, amt: in_amt, dg: (in_dg == T_BAD) ? T_MINUS : in_dg};
    end
  end

  // stage 2: shift into the non-negative digit range
  logic [UW-1:0] s2_ux;
  logic [UW-1:0] s2_uy;
  ctl_t          s2_ctl;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_ux  <= UW'(s1_x) + OFFSET;
      s2_uy  <= UW'(s1_b) + OFFSET;
      s2_ctl <= s1_ctl;
    end
  end

  // conversion stages
  xtr_t ta;
  xtr_t tb;
  ctl_t ctl_q [NCV];

  bta_conv u_conv_a (
    .clk   (clk),
    .en    (ld[S_CV +: NCV]),
    .u     (s2_ux),
    .trits (ta)
  );

  bta_conv u_conv_b (
    .clk   (clk),
    .en    (ld[S_CV +: NCV]),
    .u     (s2_uy),
    .trits (tb)
  );

  for (genvar k = 0; k < NCV; k++) begin : g_ctl
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (ld[S_CV]) begin
          ctl_q[0] <= s2_ctl;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (ld[S_CV + k]) begin
          ctl_q[k] <= ctl_q[k-1];
        end
      end
    end
  end

  // trit operation
  wtr_t       tr;
  logic [1:0] tout;

  bta_tritop u_tritop (
    .clk  (clk),
    .en   (ld[S_OP]),
    .ta   (ta),
    .tb   (tb),
    .ctl  (ctl_q[NCV-1]),
    .tr   (tr),
    .tout (tout)
  );

  // back to binary
  logic [VW-1:0] value;
  side_t         side;

  bta_sum u_sum (
    .clk   (clk),
    .en    (ld[S_SUM +: LVL]),
    .tr    (tr),
    .tout  (tout),
    .value (value),
    .side  (side)
  );

  assign m_tdata = OUTW'({side.tout, side.trits, value});
  assign m_tuser = side.ovf;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks balanced_ternary_alu item by item. A short table of directed items
// covers the operand extremes, every operation, the spare operation codes and
// the odd digit pattern. About 950 random items follow. Results without a
// hand-written value are checked against an in-bench balanced-ternary
// evaluator, while both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench import bta_pkg::*; ();

  localparam int    NT        = 64;          // trits in an exact expansion
  localparam longint MAXV     = 1743392200;  // largest value of TRITS trits
  localparam int    NDIR      = 25;
  localparam int    NRAND     = 950;
  localparam int    DRAIN_CYC = 40;

  localparam logic [OPW-1:0] OP_SPARE_FIRST = OP_SET + 1;
  localparam logic [OPW-1:0] OP_SPARE_LAST  = {OPW{1'b1}};

  typedef logic [NT-1:0][1:0] tvec_t;

  typedef struct packed {
    logic [OPW-1:0] op;
    logic [VW-1:0]  a;
    logic [VW-1:0]  b;
    logic [AW-1:0]  amt;
    logic [DGW-1:0] dg;
  } alu_req_t;

  typedef struct packed {
    logic [VW-1:0]  value;
    logic [TRW-1:0] trits;
    logic [1:0]     tout;
    logic           ovf;
  } alu_res_t;

  typedef struct packed {
    alu_req_t req;
    logic     known;
    alu_res_t res;
  } dir_row_t;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [INW-1:0]  s_tdata;
  logic [OPW-1:0]  s_tuser;
  logic            m_tvalid;
  logic            m_tready;
  logic [OUTW-1:0] m_tdata;
  logic            m_tuser;

  // expected results in order of acceptance
  alu_res_t due_buf [NDIR + NRAND];
  int       due_wr = 0;
  int       due_rd = 0;
  int       mismatch_cnt = 0;
  int       src_mode = 0;
  dir_row_t dir_tab [NDIR];

  balanced_ternary_alu i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int trit_val(logic [1:0] c);
    return (c == T_PLUS) ? 1 : (c == T_MINUS) ? -1 : 0;
  endfunction

  function automatic logic [1:0] trit_code(int v);
    return (v > 0) ? T_PLUS : (v < 0) ? T_MINUS : T_ZERO;
  endfunction

  // exact expansion, remainders folded into -1..1
  function automatic tvec_t to_trits(longint v);
    tvec_t  t;
    longint r;
    for (int i = 0; i < NT; i++) begin
      r = v % 3;
      v = v / 3;
      if (r == 2) begin
        r = -1;
        v++;
      end else if (r == -2) begin
        r = 1;
        v--;
      end
      t[i] = trit_code(int'(r));
    end
    return t;
  endfunction

  function automatic alu_res_t ternary_eval(alu_req_t q);
    alu_res_t r;
    tvec_t    ta, tb, tr;
    longint   sa, sb, acc;
    int       x, y, sh;
    r  = '0;
    if (q.op > OP_SET) return r;
    sa = longint'($signed(q.a));
    sb = longint'($signed(q.b));
    sh = int'(q.amt);
    ta = to_trits(sa);
    tr = ta;
    case (q.op)
      OP_AND, OP_OR: begin
        tb = to_trits(sb);
        for (int i = 0; i < NT; i++) begin
          x = trit_val(ta[i]);
          y = trit_val(tb[i]);
          tr[i] = trit_code((q.op == OP_AND) ? ((x < y) ? x : y) : ((x > y) ? x : y));
        end
      end
      OP_SHR: begin
        for (int i = 0; i < NT; i++) tr[i] = (i + sh < NT) ? ta[i + sh] : T_ZERO;
      end
      OP_SHL: begin
        for (int i = 0; i < NT; i++) tr[i] = (i >= sh) ? ta[i - sh] : T_ZERO;
      end
      OP_ADD: tr = to_trits(sa + sb);
      OP_SUB: tr = to_trits(sa - sb);
      OP_GET: r.tout = ta[sh];
      // the unused digit pattern counts as minus
      OP_SET: tr[sh] = (q.dg == T_BAD) ? T_MINUS : q.dg;
      default: ;
    endcase
    acc = 0;
    for (int i = TRITS - 1; i >= 0; i--) acc = acc * 3 + trit_val(tr[i]);
    r.value = acc[VW-1:0];
    for (int i = 0; i < TRITS && i < TRW / 2; i++) r.trits[2*i +: 2] = tr[i];
    for (int i = TRITS; i < NT; i++) if (tr[i] != T_ZERO) r.ovf = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t stim(logic [OPW-1:0] op, logic [VW-1:0] a,
                                    logic [VW-1:0] b, logic [AW-1:0] amt,
                                    logic [DGW-1:0] dg);
    dir_row_t d;
    d       = '0;
    d.req   = '{op: op, a: a, b: b, amt: amt, dg: dg};
    d.known = 1'b0;
    return d;
  endfunction

  function automatic dir_row_t stim_known(logic [OPW-1:0] op, logic [VW-1:0] a,
                                          logic [VW-1:0] b, logic [AW-1:0] amt,
                                          logic [DGW-1:0] dg, logic [VW-1:0] value,
                                          logic [TRW-1:0] trits, logic [1:0] tout,
                                          logic ovf);
    dir_row_t d;
    d       = stim(op, a, b, amt, dg);
    d.known = 1'b1;
    d.res   = '{value: value, trits: trits, tout: tout, ovf: ovf};
    return d;
  endfunction

  function automatic int pick_gap(int mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 75) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
    end
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VW-1:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return VW'(longint'($urandom_range(0, 32'd3486784400)) - MAXV);
    if (sel < 6) return VW'($urandom_range(0, 80) - 40);
    if (sel < 8) return $urandom;
    case ($urandom_range(0, 5))
      0: return VW'(MAXV);
      1: return VW'(-MAXV);
      2: return VW'(MAXV + 1);
      3: return VW'(-MAXV - 1);
      4: return 32'h7fff_ffff;
      default: return 32'h8000_0000;
    endcase
  endfunction

  task automatic push_item(alu_req_t q, alu_res_t want);
    int gap;
    gap = pick_gap(src_mode);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = INW'({q.dg, q.amt, q.b, q.a});
    s_tuser  = q.op;
    do @(posedge clk); while (!s_tready);
    due_buf[due_wr] = want;
    due_wr++;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // result side
  always @(posedge clk) begin
    alu_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_rd == due_wr) begin
        $error("result item with nothing expected");
        mismatch_cnt++;
      end else begin
        want = due_buf[due_rd];
        due_rd++;
        check_field("result_value", want.value, m_tdata[VW-1:0]);
        check_field("result_trits", want.trits, m_tdata[VW +: TRW]);
        check_field("trit_out", want.tout, m_tdata[VW + TRW +: 2]);
        check_field("overflow", want.ovf, m_tuser);
      end
    end
  end

  initial begin
    int hold, left, sink_mode;
    m_tready  = 1'b0;
    hold      = 0;
    left      = 0;
    sink_mode = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (left == 0) begin
        sink_mode = $urandom_range(0, 2);
        left      = $urandom_range(20, 200);
      end else begin
        left--;
      end
      if (hold > 0) begin
        m_tready = 1'b0;
        hold--;
      end else begin
        m_tready = 1'b1;
        hold     = pick_gap(sink_mode);
      end
    end
  end

  initial begin
    alu_req_t q;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    dir_tab = '{
      stim_known(OP_CONV, 0, 0, 0, 2'b00, 0, 40'h0, 2'b00, 1'b0),
      stim_known(OP_CONV, 1, 0, 0, 2'b00, 1, 40'h1, 2'b00, 1'b0),
      stim_known(OP_CONV, -1, 0, 0, 2'b00, -1, 40'h3, 2'b00, 1'b0),
      stim_known(OP_CONV, 1743392200, 0, 0, 2'b00,
                 1743392200, 40'h55_5555_5555, 2'b00, 1'b0),
      stim_known(OP_CONV, -1743392200, 0, 0, 2'b00,
                 -1743392200, 40'hff_ffff_ffff, 2'b00, 1'b0),
      // one past the top: trit 20 set, low trits all minus
      stim_known(OP_CONV, 1743392201, 0, 0, 2'b00,
                 -1743392200, 40'hff_ffff_ffff, 2'b00, 1'b1),
      stim(OP_CONV, 32'h7fff_ffff, 0, 0, 2'b00),
      stim(OP_CONV, 32'h8000_0000, 0, 0, 2'b00),
      stim(OP_AND, 32'h7fff_ffff, 32'h8000_0000, 0, 2'b00),
      stim(OP_OR, 12345, -678, 0, 2'b00),
      stim(OP_SHR, -1743392200, 0, 0, 2'b00),
      stim(OP_SHR, 1743392200, 0, 31, 2'b00),
      stim(OP_SHL, 1, 0, 19, 2'b00),
      stim(OP_SHL, -1743392200, 0, 31, 2'b00),
      stim(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 0, 2'b00),
      stim(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 0, 2'b00),
      stim_known(OP_GET, 1, 0, 0, 2'b00, 1, 40'h1, T_PLUS, 1'b0),
      stim_known(OP_GET, -1, 0, 0, 2'b00, -1, 40'h3, T_MINUS, 1'b0),
      stim(OP_GET, 32'h7fff_ffff, 0, 31, 2'b00),
      // digit set far above the kept trits
      stim_known(OP_SET, 0, 0, 31, 2'b01, 0, 40'h0, 2'b00, 1'b1),
      stim_known(OP_SET, 0, 0, 0, 2'b10, -1, 40'h3, 2'b00, 1'b0),
      stim(OP_SET, 1743392200, 0, 19, 2'b11),
      stim(OP_SET, -5, 0, 20, 2'b00),
      stim_known(OP_SPARE_FIRST, 32'h7fff_ffff, 32'h8000_0000, 31, 2'b01,
                 0, 40'h0, 2'b00, 1'b0),
      stim_known(OP_SPARE_LAST, -1, -1, 31, 2'b11, 0, 40'h0, 2'b00, 1'b0)
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NDIR; i++) begin
      if (i % 8 == 0) src_mode = $urandom_range(0, 2);
      push_item(dir_tab[i].req,
                dir_tab[i].known ? dir_tab[i].res : ternary_eval(dir_tab[i].req));
    end

    for (int i = 0; i < NRAND; i++) begin
      if (i % 50 == 0) src_mode = $urandom_range(0, 2);
      q.op  = ($urandom_range(0, 99) < 6) ?
              OPW'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)) :
              OPW'($urandom_range(OP_CONV, OP_SET));
      q.a   = pick_operand();
      q.b   = pick_operand();
      q.amt = ($urandom_range(0, 3) == 0) ? AW'($urandom_range(0, 31)) :
              AW'($urandom_range(0, TRITS));
      q.dg  = DGW'($urandom_range(0, 3));
      push_item(q, ternary_eval(q));
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (due_rd != due_wr) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (due_rd != due_wr) begin
      $error("%0d expected result items never arrived", due_wr - due_rd);
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
